// ----- rtl/tdpt_pkg.sv -----
`timescale 1ns / 1ps

package tdpt_pkg;

	// Sequencer states of the top level.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CHECK  = 4'b0010,
		ST_DIVIDE = 4'b0100,
		ST_FINISH = 4'b1000
	} tdpt_state_t;

	// Status returned by the remainder unit.
	typedef struct packed {
		logic done;
		logic zero;
	} tdpt_rem_stat_t;

endpackage

// ----- rtl/tdpt_rem.sv -----
`timescale 1ns / 1ps

module tdpt_rem #(
	parameter int VALUE_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [VALUE_BITS-1:0]     dividend,
	input  logic [VALUE_BITS-1:0]     divisor,
	output tdpt_pkg::tdpt_rem_stat_t  stat
);

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [VALUE_BITS-1:0] div_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS-1:0] rem_next;

	// Restoring division, one dividend bit per cycle, most significant first.
	// The trial value is one bit wider than the word, so the partial remainder fits.
	always_comb begin
		trial = {rem_q, quo_q[VALUE_BITS-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_next = VALUE_BITS'(trial - {1'b0, div_q});
		end else begin
			rem_next = trial[VALUE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	assign stat.done = done_q;
	assign stat.zero = (rem_q == '0);

endmodule

// ----- rtl/trial_division_prime_test.sv -----
`timescale 1ns / 1ps

// Channel     Direction  Handshake              Payload
// candidate   in         cand_valid/cand_stall  candidate
// result      out        res_valid/res_stall    tested_value, is_prime
//
// Divisors run from 2 upward and the search stops once a divisor leaves no
// remainder or the divisor squared exceeds the value, which gives the same
// answer as a search up to half the value. Every divisor is tested in the
// single remainder unit; values below 2 and negative values skip the search.
// Reset clears the sequencer and the result valid flag. A stalled result
// holds; the next result waits in ST_FINISH, and cand_stall stays high meanwhile.

module trial_division_prime_test #(
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cand_valid,
	output logic                         cand_stall,
	input  logic signed [VALUE_BITS-1:0] candidate,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic signed [VALUE_BITS-1:0] tested_value,
	output logic                         is_prime
);

	tdpt_pkg::tdpt_state_t    state_q;
	tdpt_pkg::tdpt_rem_stat_t rem_stat;

	logic [VALUE_BITS-1:0] n_q;
	logic [VALUE_BITS-1:0] d_q;
	logic [VALUE_BITS:0]   sq_q;
	logic                  prime_q;
	logic                  res_valid_q;
	logic [VALUE_BITS-1:0] tested_value_q;
	logic                  is_prime_q;
	logic                  cand_take;
	logic                  rem_start;
	logic                  out_free;

	assign cand_stall = (state_q != tdpt_pkg::ST_IDLE);
	assign cand_take  = cand_valid && !cand_stall;
	assign rem_start  = (state_q == tdpt_pkg::ST_CHECK) && !(sq_q > {1'b0, n_q});
	assign out_free   = !res_valid_q || !res_stall;

	tdpt_rem #(
		.VALUE_BITS(VALUE_BITS)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (n_q),
		.divisor  (d_q),
		.stat     (rem_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tdpt_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if ((state_q == tdpt_pkg::ST_FINISH) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				tdpt_pkg::ST_IDLE: begin
					if (cand_take) begin
						// Negative values and values below 2 skip the search.
						if (candidate[VALUE_BITS-1] ||
						    (unsigned'(candidate) < VALUE_BITS'(2))) begin
							state_q <= tdpt_pkg::ST_FINISH;
						end else begin
							state_q <= tdpt_pkg::ST_CHECK;
						end
					end
				end
				tdpt_pkg::ST_CHECK: begin
					if (sq_q > {1'b0, n_q}) begin
						state_q <= tdpt_pkg::ST_FINISH;
					end else begin
						state_q <= tdpt_pkg::ST_DIVIDE;
					end
				end
				tdpt_pkg::ST_DIVIDE: begin
					if (rem_stat.done) begin
						if (rem_stat.zero) begin
							state_q <= tdpt_pkg::ST_FINISH;
						end else begin
							state_q <= tdpt_pkg::ST_CHECK;
						end
					end
				end
				tdpt_pkg::ST_FINISH: begin
					if (out_free) begin
						state_q <= tdpt_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tdpt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tdpt_pkg::ST_IDLE: begin
				n_q     <= unsigned'(candidate);
				d_q     <= VALUE_BITS'(2);
				sq_q    <= (VALUE_BITS + 1)'(4);
				prime_q <= 1'b0;
			end
			tdpt_pkg::ST_CHECK: begin
				if (sq_q > {1'b0, n_q}) begin
					prime_q <= 1'b1;
				end
			end
			tdpt_pkg::ST_DIVIDE: begin
				if (rem_stat.done && !rem_stat.zero) begin
					// (d + 1)^2 = d^2 + 2d + 1 keeps the square without a multiplier.
					sq_q <= sq_q + {d_q, 1'b1};
					d_q  <= d_q + VALUE_BITS'(1);
				end
			end
			tdpt_pkg::ST_FINISH: begin
				if (out_free) begin
					tested_value_q <= n_q;
					is_prime_q     <= prime_q;
				end
			end
			default: begin
				prime_q <= 1'b0;
			end
		endcase
	end

	assign res_valid    = res_valid_q;
	assign tested_value = signed'(tested_value_q);
	assign is_prime     = is_prime_q;

endmodule
